// File: rtl/delta_list_timer_queue_macros.svh
// Assertion macros used by the timer queue RTL.
`ifndef DELTA_LIST_TIMER_QUEUE_MACROS_SVH
`define DELTA_LIST_TIMER_QUEUE_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define DLTQ_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define DLTQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define DLTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/dltq_pkg.sv
// Package with the shared constants and codes of the delta-list timer queue.
`default_nettype none

package dltq_pkg;

   localparam int NUM_TIMERS_DEF = 8;
   localparam int MAX_RESULTS    = 8;
   localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

   localparam int DELTA_W    = 16;
   localparam int SIG_W      = 8;
   localparam int PAY_W      = 16;
   localparam int OWN_W      = 8;
   localparam int DATA_W     = SIG_W + PAY_W + OWN_W;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [1:0] {
      STATUS_ADDED   = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EXPIRED = 2'd2,
      STATUS_NONE    = 2'd3
   } status_type;

   typedef enum logic {
      KIND_ADD   = 1'b0,
      KIND_CLOCK = 1'b1
   } kind_type;

endpackage

`default_nettype wire

// File: rtl/dltq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module dltq_ram #(
   parameter int WIDTH = dltq_pkg::DATA_W,
   parameter int DEPTH = dltq_pkg::NUM_TIMERS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/delta_list_timer_queue.sv
// Delta-list timer queue: a pool of timer slots kept as a list sorted by relative expiry.
// An add beat takes a slot from the free list and walks the pending list one entry at a
// time, because each step reads the link and delta memories through their single
// registered read ports. An add refused because the pool is full gets a full status. A
// clock beat removes expired timers from the head of the list, at most eight expired timers
// per clock beat, each reported in its own result beat with the last one marked by tlast.
// The block takes no new beat until all results of the current one are delivered.
// All storage needs no clearing pass after reset.
`default_nettype none

`include "delta_list_timer_queue_macros.svh"

module delta_list_timer_queue #(
   parameter int NUM_TIMERS = dltq_pkg::NUM_TIMERS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // signal_code, payload, owner, delay_ticks, clock_now
   input  wire logic [dltq_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // out_signal, out_payload, out_owner
   output logic      [dltq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic      [1:0]                      rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int SLOT_W = $clog2(NUM_TIMERS);
   localparam int LINK_W = $clog2(NUM_TIMERS + 1);
   localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_TIMERS);
   localparam int DW = dltq_pkg::DELTA_W;
   localparam int CW = dltq_pkg::CNT_W;

   typedef enum logic [3:0] {
      S_IDLE, S_AFREE, S_ACMP, S_ALINK, S_AINS1, S_AINS2,
      S_CCHK, S_CDATA, S_CNEXT, S_OUT
   } state_type;

   state_type                  state_ff, state_in;
   logic [LINK_W-1:0]          used_head_ff, used_head_in;
   logic [LINK_W-1:0]          free_head_ff, free_head_in;
   logic [DW-1:0]              last_exp_ff, last_exp_in;
   logic [DW-1:0]              t_ff, t_in;
   logic [DW-1:0]              now_ff, now_in;
   logic [DW-1:0]              fix_ff, fix_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic [SLOT_W-1:0]          cur_ff, cur_in;
   logic [LINK_W-1:0]          nxt_ff, nxt_in;
   logic                       at_head_ff, at_head_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [NUM_TIMERS-1:0]      link_vld_ff, link_vld_in;
   logic                       lk_vld_ff, lk_vld_in;
   logic [SLOT_W-1:0]          lk_addr_ff, lk_addr_in;
   logic [1:0]                 out_status_ff, out_status_in;
   logic [dltq_pkg::DATA_W-1:0] out_data_ff, out_data_in;
   logic                       out_last_ff, out_last_in;

   logic                       d_we, d_re, l_we, l_re, m_we, m_re;
   logic [SLOT_W-1:0]          d_waddr, d_raddr, l_waddr, l_raddr, m_waddr, m_raddr;
   logic [DW-1:0]              d_wdata, delta_q;
   logic [LINK_W-1:0]          l_wdata, link_ram_q, link_q;
   logic [dltq_pkg::DATA_W-1:0] m_wdata, data_q;
   logic [DW-1:0]              diff;

   dltq_ram #(.WIDTH(DW), .DEPTH(NUM_TIMERS)) u_delta_ram (
      .clock(clock), .wr_en(d_we), .wr_addr(d_waddr), .wr_data(d_wdata),
      .rd_en(d_re), .rd_addr(d_raddr), .rd_data(delta_q)
   );

   dltq_ram #(.WIDTH(LINK_W), .DEPTH(NUM_TIMERS)) u_link_ram (
      .clock(clock), .wr_en(l_we), .wr_addr(l_waddr), .wr_data(l_wdata),
      .rd_en(l_re), .rd_addr(l_raddr), .rd_data(link_ram_q)
   );

   dltq_ram #(.WIDTH(dltq_pkg::DATA_W), .DEPTH(NUM_TIMERS)) u_data_ram (
      .clock(clock), .wr_en(m_we), .wr_addr(m_waddr), .wr_data(m_wdata),
      .rd_en(m_re), .rd_addr(m_raddr), .rd_data(data_q)
   );

   // A link entry never written reads as its reset value, the next slot.
   assign link_q = lk_vld_ff ? link_ram_q : (LINK_W'(lk_addr_ff) + LINK_W'(1));
   assign diff   = now_ff - last_exp_ff;

   always_comb begin
      state_in      = state_ff;
      used_head_in  = used_head_ff;
      free_head_in  = free_head_ff;
      last_exp_in   = last_exp_ff;
      t_in          = t_ff;
      now_in        = now_ff;
      fix_in        = fix_ff;
      slot_in       = slot_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      at_head_in    = at_head_ff;
      count_in      = count_ff;
      link_vld_in   = link_vld_ff;
      out_status_in = out_status_ff;
      out_data_in   = out_data_ff;
      out_last_in   = out_last_ff;
      d_we = 1'b0; d_re = 1'b0; l_we = 1'b0; l_re = 1'b0; m_we = 1'b0; m_re = 1'b0;
      d_waddr = '0; d_raddr = '0; l_waddr = '0; l_raddr = '0; m_waddr = '0; m_raddr = '0;
      d_wdata = '0; l_wdata = '0;
      m_wdata = req_tdata[dltq_pkg::DATA_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == dltq_pkg::KIND_ADD) begin
                  if (free_head_ff >= NIL) begin
                     out_status_in = dltq_pkg::STATUS_FULL;
                     out_data_in   = '0;
                     out_last_in   = 1'b1;
                     state_in      = S_OUT;
                  end else begin
                     slot_in  = free_head_ff[SLOT_W-1:0];
                     t_in     = req_tdata[47:32];
                     m_we     = 1'b1;
                     m_waddr  = free_head_ff[SLOT_W-1:0];
                     l_re     = 1'b1;
                     l_raddr  = free_head_ff[SLOT_W-1:0];
                     state_in = S_AFREE;
                  end
               end else begin
                  now_in   = req_tdata[63:48];
                  count_in = '0;
                  if (used_head_ff >= NIL) begin
                     out_status_in = dltq_pkg::STATUS_NONE;
                     out_data_in   = '0;
                     out_last_in   = 1'b1;
                     state_in      = S_OUT;
                  end else begin
                     d_re     = 1'b1;
                     d_raddr  = used_head_ff[SLOT_W-1:0];
                     l_re     = 1'b1;
                     l_raddr  = used_head_ff[SLOT_W-1:0];
                     state_in = S_CCHK;
                  end
               end
            end
         end
         S_AFREE: begin
            free_head_in = link_q;
            at_head_in   = 1'b1;
            nxt_in       = used_head_ff;
            if (used_head_ff >= NIL) begin
               nxt_in   = NIL;
               state_in = S_AINS1;
            end else begin
               d_re     = 1'b1;
               d_raddr  = used_head_ff[SLOT_W-1:0];
               state_in = S_ACMP;
            end
         end
         S_ACMP: begin
            if (delta_q > t_ff) begin
               fix_in   = delta_q - t_ff;
               state_in = S_AINS1;
            end else begin
               t_in       = t_ff - delta_q;
               cur_in     = nxt_ff[SLOT_W-1:0];
               at_head_in = 1'b0;
               l_re       = 1'b1;
               l_raddr    = nxt_ff[SLOT_W-1:0];
               state_in   = S_ALINK;
            end
         end
         S_ALINK: begin
            if (link_q >= NIL) begin
               nxt_in   = NIL;
               state_in = S_AINS1;
            end else begin
               nxt_in   = link_q;
               d_re     = 1'b1;
               d_raddr  = link_q[SLOT_W-1:0];
               state_in = S_ACMP;
            end
         end
         S_AINS1: begin
            d_we    = 1'b1;
            d_waddr = slot_ff;
            d_wdata = t_ff;
            l_we    = 1'b1;
            l_waddr = slot_ff;
            l_wdata = nxt_ff;
            link_vld_in[slot_ff] = 1'b1;
            if (at_head_ff) begin
               used_head_in = LINK_W'(slot_ff);
            end
            state_in = S_AINS2;
         end
         S_AINS2: begin
            if (nxt_ff < NIL) begin
               d_we    = 1'b1;
               d_waddr = nxt_ff[SLOT_W-1:0];
               d_wdata = fix_ff;
            end
            if (!at_head_ff) begin
               l_we    = 1'b1;
               l_waddr = cur_ff;
               l_wdata = LINK_W'(slot_ff);
               link_vld_in[cur_ff] = 1'b1;
            end
            out_status_in = dltq_pkg::STATUS_ADDED;
            out_data_in   = '0;
            out_last_in   = 1'b1;
            state_in      = S_OUT;
         end
         S_CCHK: begin
            if (diff < delta_q) begin
               out_status_in = dltq_pkg::STATUS_NONE;
               out_data_in   = '0;
               out_last_in   = 1'b1;
               state_in      = (count_ff == '0) ? S_OUT : S_IDLE;
            end else begin
               used_head_in = link_q;
               l_we         = 1'b1;
               l_waddr      = used_head_ff[SLOT_W-1:0];
               l_wdata      = free_head_ff;
               link_vld_in[used_head_ff[SLOT_W-1:0]] = 1'b1;
               free_head_in = used_head_ff;
               last_exp_in  = now_ff;
               m_re         = 1'b1;
               m_raddr      = used_head_ff[SLOT_W-1:0];
               count_in     = count_ff + CW'(1);
               state_in     = S_CDATA;
            end
         end
         S_CDATA: begin
            out_status_in = dltq_pkg::STATUS_EXPIRED;
            out_data_in   = data_q;
            if (count_ff == CW'(dltq_pkg::MAX_RESULTS) || used_head_ff >= NIL) begin
               out_last_in = 1'b1;
               state_in    = S_OUT;
            end else begin
               d_re     = 1'b1;
               d_raddr  = used_head_ff[SLOT_W-1:0];
               l_re     = 1'b1;
               l_raddr  = used_head_ff[SLOT_W-1:0];
               state_in = S_CNEXT;
            end
         end
         S_CNEXT: begin
            out_last_in = (diff < delta_q);
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = out_last_ff ? S_IDLE : S_CCHK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign lk_vld_in  = l_re ? link_vld_ff[l_raddr] : lk_vld_ff;
   assign lk_addr_in = l_re ? l_raddr : lk_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_head_ff <= NIL;
         free_head_ff <= '0;
         last_exp_ff  <= '0;
         count_ff     <= '0;
         link_vld_ff  <= '0;
         lk_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_head_ff <= used_head_in;
         free_head_ff <= free_head_in;
         last_exp_ff  <= last_exp_in;
         count_ff     <= count_in;
         link_vld_ff  <= link_vld_in;
         lk_vld_ff    <= lk_vld_in;
      end
      lk_addr_ff    <= lk_addr_in;
      t_ff          <= t_in;
      now_ff        <= now_in;
      fix_ff        <= fix_in;
      slot_ff       <= slot_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      at_head_ff    <= at_head_in;
      out_status_ff <= out_status_in;
      out_data_ff   <= out_data_in;
      out_last_ff   <= out_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

   `DLTQ_ASSERT_ALWAYS(a_heads_distinct,
      used_head_ff >= NIL || free_head_ff >= NIL || used_head_ff != free_head_ff,
      "Free list and pending list share a head slot.")
   `DLTQ_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(dltq_pkg::MAX_RESULTS),
      "More expiries than allowed in one clock beat.")
   `DLTQ_ASSERT_IMPLY(a_full_status,
      rsp_tvalid && rsp_tuser == dltq_pkg::STATUS_FULL, free_head_ff == NIL,
      "Pool reported full while a slot is free.")
   `DLTQ_ASSERT_NEXT(a_expiry_time, state_ff == S_CCHK && !(diff < delta_q),
      last_exp_ff == $past(now_ff), "Expiry time not updated on removal.")

endmodule

`default_nettype wire

// File: sim/tb_delta_list_timer_queue.sv
// Testbench for the delta-list timer queue: directed and random beats checked against a predictor.
`default_nettype none

module tb_delta_list_timer_queue;

   localparam int NT        = dltq_pkg::NUM_TIMERS_DEF;
   localparam int NIL       = NT;
   localparam int CYCLE_MAX = 400000;

   typedef struct {
      dltq_pkg::kind_type          kind;
      logic [dltq_pkg::SIG_W-1:0]  sig;
      logic [dltq_pkg::PAY_W-1:0]  pay;
      logic [dltq_pkg::OWN_W-1:0]  own;
      logic [15:0]                 delay;
      logic [15:0]                 now;
   } timer_req_type;

   typedef struct {
      dltq_pkg::status_type        status;
      logic [dltq_pkg::SIG_W-1:0]  sig;
      logic [dltq_pkg::PAY_W-1:0]  pay;
      logic [dltq_pkg::OWN_W-1:0]  own;
      logic                        last;
   } timer_rsp_type;

   class timer_queue_checker;
      logic [dltq_pkg::DELTA_W-1:0] delta [NT];
      logic [dltq_pkg::SIG_W-1:0]   sig   [NT];
      logic [dltq_pkg::PAY_W-1:0]   pay   [NT];
      logic [dltq_pkg::OWN_W-1:0]   own   [NT];
      int                           link  [NT];
      int                           used_head;
      int                           free_head;
      int                           armed;
      logic [15:0]                  last_fire;
      timer_rsp_type                expected_rsp [$];
      int                           mismatches;

      function new();
         for (int i = 0; i < NT; i++) begin
            delta[i] = '0;
            sig[i]   = '0;
            pay[i]   = '0;
            own[i]   = '0;
            link[i]  = i + 1;
         end
         used_head  = NIL;
         free_head  = 0;
         armed      = 0;
         last_fire  = '0;
         mismatches = 0;
      endfunction

      function dltq_pkg::status_type insert_timer(timer_req_type r);
         int          slot;
         int          cur;
         int          nxt;
         logic [15:0] rem;
         if (free_head >= NT) return dltq_pkg::STATUS_FULL;
         slot       = free_head;
         free_head  = link[slot];
         link[slot] = NIL;
         sig[slot]  = r.sig;
         pay[slot]  = r.pay;
         own[slot]  = r.own;
         armed++;
         if (used_head >= NT) begin
            delta[slot] = r.delay;
            used_head   = slot;
            return dltq_pkg::STATUS_ADDED;
         end
         if (delta[used_head] > r.delay) begin
            delta[slot]      = r.delay;
            delta[used_head] = delta[used_head] - r.delay;
            link[slot]       = used_head;
            used_head        = slot;
            return dltq_pkg::STATUS_ADDED;
         end
         cur = used_head;
         rem = r.delay;
         while (cur < NT) begin
            rem = rem - delta[cur];
            nxt = link[cur];
            if (nxt >= NT || delta[nxt] > rem) begin
               if (nxt < NT) delta[nxt] = delta[nxt] - rem;
               else nxt = NIL;
               delta[slot] = rem;
               link[slot]  = nxt;
               link[cur]   = slot;
               break;
            end
            cur = nxt;
         end
         return dltq_pkg::STATUS_ADDED;
      endfunction

      function void note_request(timer_req_type r);
         timer_rsp_type e;
         timer_rsp_type fired [$];
         logic [15:0]   diff;
         int            h;
         e = '{dltq_pkg::STATUS_NONE, '0, '0, '0, 1'b1};
         if (r.kind == dltq_pkg::KIND_ADD) begin
            e.status = insert_timer(r);
            expected_rsp.push_back(e);
            return;
         end
         while (fired.size() < dltq_pkg::MAX_RESULTS && used_head < NT) begin
            diff = r.now - last_fire;
            h    = used_head;
            if (diff < delta[h]) break;
            used_head = link[h];
            link[h]   = free_head;
            free_head = h;
            last_fire = r.now;
            armed--;
            fired.push_back('{dltq_pkg::STATUS_EXPIRED, sig[h], pay[h], own[h], 1'b0});
         end
         if (fired.size() == 0) begin
            expected_rsp.push_back(e);
            return;
         end
         fired[fired.size() - 1].last = 1'b1;
         foreach (fired[i]) expected_rsp.push_back(fired[i]);
      endfunction

      function void check_response(logic [dltq_pkg::RSP_DATA_W-1:0] data,
                                   logic [1:0] status, logic last);
         timer_rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("unexpected result beat: status %0d data %h", status, data);
            mismatches++;
            return;
         end
         e = expected_rsp.pop_front();
         if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            mismatches++;
         end
         if (data[7:0] !== e.sig) begin
            $error("out_signal: expected %0d, actual %0d", e.sig, data[7:0]);
            mismatches++;
         end
         if (data[23:8] !== e.pay) begin
            $error("out_payload: expected %0d, actual %0d", e.pay, data[23:8]);
            mismatches++;
         end
         if (data[31:24] !== e.own) begin
            $error("out_owner: expected %0d, actual %0d", e.own, data[31:24]);
            mismatches++;
         end
         if (last !== e.last) begin
            $error("last_result: expected %0d, actual %0d", e.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [dltq_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [dltq_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]                      rsp_tuser;
   logic                            rsp_tlast;

   timer_queue_checker sb;
   bit                 steady;
   int                 hold_cycles;
   int                 cycle_count;
   logic [15:0]        wall_clock;

   delta_list_timer_queue uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_MAX) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(timer_req_type r);
      while ($urandom_range(0, 99) < (steady ? 0 : 15)) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser  = r.kind;
      req_tdata  = {r.now, r.delay, r.own, r.pay, r.sig};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_add(logic [15:0] delay, logic [7:0] s, logic [15:0] p, logic [7:0] o);
      timer_req_type r;
      r = '{dltq_pkg::KIND_ADD, s, p, o, delay, 16'($urandom)};
      send_beat(r);
   endtask

   task automatic send_clock(logic [15:0] now);
      timer_req_type r;
      r = '{dltq_pkg::KIND_CLOCK, 8'($urandom), 16'($urandom), 8'($urandom),
            16'($urandom), now};
      send_beat(r);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready  = 1'b0;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= (steady ? 0 : 15));
         end
      end
   end

   initial begin
      int          pick;
      logic [15:0] delay;
      logic [15:0] step;
      sb          = new();
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      rsp_tready  = 1'b0;
      steady      = 1'b0;
      hold_cycles = 0;
      cycle_count = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Empty list, then a full pool with equal delays, an earlier insert and a refused add.
      send_clock(16'h0000);
      send_add(16'h0000, 8'hFF, 16'hFFFF, 8'hFF);
      send_add(16'hFFFF, 8'h00, 16'h0000, 8'h00);
      send_add(16'd10, 8'h11, 16'h1111, 8'h01);
      send_add(16'd10, 8'h22, 16'h2222, 8'h02);
      send_add(16'd5, 8'h33, 16'h3333, 8'h03);
      send_add(16'd0, 8'h44, 16'h4444, 8'h04);
      send_add(16'd20, 8'h55, 16'h5555, 8'h05);
      send_add(16'd30, 8'h66, 16'h6666, 8'h06);
      send_add(16'd1, 8'h77, 16'h7777, 8'h07);
      send_clock(16'h0000);
      send_clock(16'd12);
      send_clock(16'hFFFF);
      send_clock(16'h0000);
      while (sb.armed > 0) send_clock(sb.last_fire + 16'hFFFF);
      send_clock(sb.last_fire + 16'hFFFF);
      // Eight timers due at once give the longest burst of result beats.
      for (int i = 0; i < NT; i++) send_add(16'd0, 8'(i), 16'($urandom), 8'(i + 8'h80));
      send_clock(sb.last_fire);

      wall_clock = sb.last_fire;
      for (int n = 0; n < 400; n++) begin
         if (n == 150) hold_cycles = 400;
         if (n == 250) begin
            while (sb.expected_rsp.size() != 0) @(negedge clock);
         end
         steady = (n >= 300 && n < 360);
         if ($urandom_range(0, 99) < 55) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) delay = 16'($urandom_range(0, 40));
            else if (pick < 90) delay = 16'($urandom_range(0, 1000));
            else delay = 16'($urandom);
            send_add(delay, 8'($urandom), 16'($urandom), 8'($urandom));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) step = 16'($urandom_range(0, 30));
            else if (pick < 90) step = 16'($urandom_range(0, 2000));
            else step = 16'($urandom);
            wall_clock = wall_clock + step;
            send_clock(wall_clock);
         end
      end
      steady = 1'b0;

      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/dltq_pkg.sv
rtl/dltq_ram.sv
rtl/delta_list_timer_queue.sv
sim/tb_delta_list_timer_queue.sv
